>>> rtl/bfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the Bloom filter membership block
// Field widths, register indexes, the controller state encoding, the command
// and status groups between controller and datapath, and the remainder step.
// ----------------------------------------------------------------------------
package bfm_pkg;

	// Field and register widths.
	localparam int HASH_W      = 32;
	localparam int NHASH_W     = 5;
	localparam int NBITS_W     = 17;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 17;
	localparam int S_TDATA_W   = 64;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 8;

	// Remainder unit: two dividend bits per cycle over a 32-bit word.
	localparam int MOD_STEPS   = 16;
	localparam int MOD_CNT_W   = 5;
	localparam int MIN_BITS    = 8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 1'b1;

	// Reset values of the registers.
	localparam logic [NHASH_W-1:0] NUM_HASHES_RST = 5'd7;
	localparam logic [NBITS_W-1:0] NUM_BITS_RST   = 17'd65536;

	// Operation codes.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_PREP,
		ST_PROBE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic load;
		logic mod_step;
		logic prep;
		logic probe_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic no_probes;
		logic mod_done;
		logic probe_last;
		logic out_free;
	} status_t;

	// One restoring remainder step: shift in one dividend bit, subtract the
	// modulus once if the partial remainder reached it.
	function automatic logic [NBITS_W-1:0] rem_step(input logic [NBITS_W-1:0] r,
			input logic b, input logic [NBITS_W-1:0] m);
		logic [NBITS_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[NBITS_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/bfm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_ctrl: sequencer of the Bloom filter membership block
// Walks the clearing pass after reset and, per request, the remainder and
// probe phases, skipped when no probe is due, and the hand-off to the output stage.
// ----------------------------------------------------------------------------
module bfm_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  bfm_pkg::status_t sts,
	output bfm_pkg::cmd_t    cmd
);
	import bfm_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.no_probes ? ST_DONE : ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_PROBE;
			end
			ST_PROBE: begin
				cmd.probe_step = 1'b1;
				if (sts.probe_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/bfm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_datapath: remainder lanes, probe index stepping and the filter bit store
// Reduces the two hash words and the word wrap constant modulo the filter
// size, then steps the probe index by the reduced stride, one probe a cycle.
// ----------------------------------------------------------------------------
module bfm_datapath #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  bfm_pkg::cmd_t                      cmd,
	output bfm_pkg::status_t                   sts,
	input  wire                                in_op,
	input  wire                                in_key_empty,
	input  wire [bfm_pkg::HASH_W-1:0]          in_first_hash,
	input  wire [bfm_pkg::HASH_W-1:0]          in_second_hash,
	input  wire [bfm_pkg::NHASH_W-1:0]         num_hashes,
	input  wire [bfm_pkg::NBITS_W-1:0]         num_bits,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               out_present
);
	import bfm_pkg::*;

	localparam int AW = $clog2(MAX_BITS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BITS - 1);
	localparam logic [NBITS_W-1:0] M_MAX = NBITS_W'(MAX_BITS);
	localparam logic [NHASH_W-1:0] K_MAX = NHASH_W'(MAX_HASHES);

	// Filter bit store.
	logic mem [MAX_BITS];
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] mem_addr;
	logic          rd_s1;
	logic          rd_vld_s1;

	// Per-request registers.
	logic                 op_q;
	logic [NHASH_W-1:0]   k_q;
	logic [NBITS_W-1:0]   m_q;
	logic [HASH_W-1:0]    acc_q;
	logic [HASH_W-1:0]    h2_q;
	logic [HASH_W-1:0]    d1_q;
	logic [HASH_W-1:0]    d2_q;
	logic [NBITS_W-1:0]   r1_q;
	logic [NBITS_W-1:0]   r2_q;
	logic [NBITS_W-1:0]   rw_q;
	logic [NBITS_W-1:0]   c_q;
	logic [MOD_CNT_W-1:0] step_q;
	logic                 all_set_q;

	// Effective register values at request time.
	logic [NHASH_W-1:0] k_eff;
	logic [NBITS_W-1:0] m_eff;

	// Probe stepping.
	logic [HASH_W:0]    acc_sum;
	logic [NBITS_W:0]   idx_sum;
	logic [NBITS_W-1:0] idx_red;
	logic [NBITS_W-1:0] idx_nxt;
	logic [NBITS_W:0]   wrap_inc;

	// Saturate the registers to their usable ranges.
	always_comb begin
		if (32'(num_hashes) > MAX_HASHES) begin
			k_eff = K_MAX;
		end else begin
			k_eff = num_hashes;
		end
		if (num_bits < NBITS_W'(MIN_BITS)) begin
			m_eff = NBITS_W'(MIN_BITS);
		end else if (32'(num_bits) > MAX_BITS) begin
			m_eff = M_MAX;
		end else begin
			m_eff = num_bits;
		end
	end

	// Next probe index: add the reduced stride and, on a carry out of the
	// 32-bit sum, take away 2^32 mod m.
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, h2_q};
		idx_sum = {1'b0, r1_q} + {1'b0, r2_q};
		if (idx_sum >= {1'b0, m_q}) begin
			idx_sum = idx_sum - {1'b0, m_q};
		end
		idx_red = idx_sum[NBITS_W-1:0];
		if (!acc_sum[HASH_W]) begin
			idx_nxt = idx_red;
		end else if (idx_red >= c_q) begin
			idx_nxt = idx_red - c_q;
		end else begin
			idx_nxt = NBITS_W'(({1'b0, idx_red} + {1'b0, m_q}) - {1'b0, c_q});
		end
		wrap_inc = {1'b0, rw_q} + 1'b1;
	end

	// Request registers and remainder lanes.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			k_q   <= k_eff;
			m_q   <= m_eff;
			acc_q <= in_first_hash;
			h2_q  <= in_second_hash;
			d1_q  <= in_first_hash;
			d2_q  <= in_second_hash;
			r1_q  <= '0;
			r2_q  <= '0;
			rw_q  <= '0;
		end else if (cmd.mod_step) begin
			r1_q <= rem_step(rem_step(r1_q, d1_q[HASH_W-1], m_q), d1_q[HASH_W-2], m_q);
			r2_q <= rem_step(rem_step(r2_q, d2_q[HASH_W-1], m_q), d2_q[HASH_W-2], m_q);
			rw_q <= rem_step(rem_step(rw_q, 1'b1, m_q), 1'b1, m_q);
			d1_q <= {d1_q[HASH_W-3:0], 2'b00};
			d2_q <= {d2_q[HASH_W-3:0], 2'b00};
		end else if (cmd.prep) begin
			c_q <= (wrap_inc == {1'b0, m_q}) ? '0 : wrap_inc[NBITS_W-1:0];
		end else if (cmd.probe_step) begin
			acc_q <= acc_sum[HASH_W-1:0];
			r1_q  <= idx_nxt;
		end
	end

	// Step counter, clearing address and check accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			clr_addr_q <= '0;
			rd_vld_s1  <= 1'b0;
			all_set_q  <= 1'b1;
		end else begin
			rd_vld_s1 <= cmd.probe_step & (op_q == OP_CHECK);
			if (cmd.load) begin
				step_q    <= '0;
				all_set_q <= 1'b1;
			end else if (cmd.mod_step) begin
				step_q <= sts.mod_done ? '0 : step_q + 1'b1;
			end else if (cmd.probe_step) begin
				step_q <= step_q + 1'b1;
			end
			if (rd_vld_s1 && !rd_s1) begin
				all_set_q <= 1'b0;
			end
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Single-ported bit store: clearing pass, set on add, read on check.
	assign mem_addr = cmd.clear_en ? clr_addr_q : AW'(r1_q);

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			mem[mem_addr] <= 1'b0;
		end else if (cmd.probe_step && (op_q == OP_ADD)) begin
			mem[mem_addr] <= 1'b1;
		end
		rd_s1 <= mem[mem_addr];
	end

	// Output stage: holds one result while the next request is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_present <= (op_q == OP_CHECK) & all_set_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.clear_done = (clr_addr_q == LAST_ADDR);
		sts.no_probes  = in_key_empty | (k_eff == '0);
		sts.mod_done   = (step_q == MOD_CNT_W'(MOD_STEPS - 1));
		sts.probe_last = (step_q == k_q - 1'b1);
		sts.out_free   = !out_valid | out_ready;
	end

endmodule
`default_nettype wire

>>> rtl/bloom_filter_membership_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_membership_top: Bloom filter bit store with double hashing
// Adds keys to, or checks keys against, a store of MAX_BITS filter bits.
// ----------------------------------------------------------------------------
// Usage:
// - The slave channel carries one request: tuser holds the operation (add or
//   check) and the empty-key flag, tdata the two 32-bit hash words of a key.
// - The master channel returns one result per request: present in bit 0.
// - The configuration channel writes num_hashes (index 0) and num_bits
//   (index 1); write only while no request is in flight.
// - After reset the block clears its bit store, one bit per cycle, over all
//   MAX_BITS addresses; s_tready stays low until that pass is done.
// - A request with k probes passes, from acceptance to a valid result,
//   through the reduction of both hash words modulo num_bits (two bits per
//   cycle), a step that prepares the wrap correction, the probes of the
//   single-ported bit store, one per cycle, and a step that collects the last
//   read. An empty key or zero probes skips straight to the result. The next
//   request is accepted in the cycle after the result goes to the output register.
// - The output register holds one result; if the receiver stalls, a second
//   finished result waits inside the block and no new request is accepted.
// ----------------------------------------------------------------------------
module bloom_filter_membership_top #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Request channel.
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [bfm_pkg::S_TDATA_W-1:0]        s_tdata,  // first_hash, second_hash
	input  wire [bfm_pkg::S_TUSER_W-1:0]        s_tuser,  // op, key_empty
	// Result channel.
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [bfm_pkg::M_TDATA_W-1:0]       m_tdata,  // present, zero fill
	// Configuration write channel.
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [bfm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [bfm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import bfm_pkg::*;

	logic [NHASH_W-1:0] num_hashes_q;
	logic [NBITS_W-1:0] num_bits_q;
	cmd_t               cmd;
	status_t            sts;
	logic               present;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q <= NUM_HASHES_RST;
			num_bits_q   <= NUM_BITS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NUM_HASHES: num_hashes_q <= cfg_data[NHASH_W-1:0];
				CFG_NUM_BITS:   num_bits_q   <= cfg_data[NBITS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfm_datapath #(
		.MAX_BITS   (MAX_BITS),
		.MAX_HASHES (MAX_HASHES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_op          (s_tuser[0]),
		.in_key_empty   (s_tuser[1]),
		.in_first_hash  (s_tdata[HASH_W-1:0]),
		.in_second_hash (s_tdata[2*HASH_W-1:HASH_W]),
		.num_hashes     (num_hashes_q),
		.num_bits       (num_bits_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_present    (present)
	);

	// Result word: present in bit 0, zeros above.
	assign m_tdata = {{(M_TDATA_W-1){1'b0}}, present};

endmodule
`default_nettype wire
